// ===== rtl/ecf_pkg.sv =====
`default_nettype none
package ecf_pkg;

  localparam int BehindEchoesDef = 15;
  localparam int AheadEchoesDef  = 15;
  localparam int CoordW          = 12;
  localparam int DistW           = 6;
  localparam int IndexW          = 5;
  localparam logic [DistW-1:0] DistReset = 6'd8;

  typedef struct packed {
    logic                     first_point;
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
  } in_t;

  typedef struct packed {
    logic signed [IndexW-1:0] echo_index;
    logic signed [CoordW-1:0] echo_x;
    logic signed [CoordW-1:0] echo_y;
    logic                     last_of_run;
  } out_t;

  // one echo step: segment from a to b, offset applied at b
  typedef struct packed {
    logic signed [CoordW-1:0] ax;
    logic signed [CoordW-1:0] ay;
    logic signed [CoordW-1:0] bx;
    logic signed [CoordW-1:0] by;
    logic                     lead;
    logic [DistW-1:0]         gap;
  } step_req_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQX, ST_SQY, ST_ROOT, ST_MULX, ST_DIVX, ST_MULY, ST_DIVY, ST_FIN
  } step_state_t;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_GO, S_WAIT, S_EMIT_RD, S_EMIT_LD, S_EMIT_HOLD
  } seq_state_t;

  function automatic logic signed [CoordW-1:0] sat_coord(input logic signed [19:0] v);
    logic signed [CoordW-1:0] r;
    if (v < -20'sd2048) begin
      r = -12'sd2048;
    end else if (v > 20'sd2047) begin
      r = 12'sd2047;
    end else begin
      r = v[CoordW-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ecf_ram.sv =====
`default_nettype none
module ecf_ram #(
  parameter int Width = 24,
  parameter int Depth = 31
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/ecf_step.sv =====
`default_nettype none
module ecf_step (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire ecf_pkg::step_req_t req,
  output logic                   done,
  output logic signed [11:0]     res_x,
  output logic signed [11:0]     res_y
);
  ecf_pkg::step_state_t st_r, st_nxt;

  logic [11:0]        mx_r, mx_nxt, my_r, my_nxt;
  logic               negx_r, negx_nxt, negy_r, negy_nxt;
  logic signed [11:0] bx_r, bx_nxt, by_r, by_nxt;
  logic               lead_r, lead_nxt;
  logic [5:0]         dist_r, dist_nxt;
  logic [25:0]        acc_r, acc_nxt;
  logic [25:0]        root_r, root_nxt;
  logic [25:0]        bit_r, bit_nxt;
  logic [12:0]        len_r, len_nxt;
  logic [12:0]        rem_r, rem_nxt;
  logic [17:0]        q_r, q_nxt, qx_r, qx_nxt;
  logic [4:0]         cnt_r, cnt_nxt;
  logic               zero_r, zero_nxt;

  logic signed [12:0] dx, dy;
  logic [11:0]        mul_a, mul_b;
  logic [23:0]        prod;
  logic [26:0]        sub_a, sub_b, diff;
  logic               ge;
  logic [13:0]        trial;
  logic [25:0]        root_step;
  logic signed [19:0] ox, oy, sx, sy;

  assign dx    = 13'(req.bx) - 13'(req.ax);
  assign dy    = 13'(req.by) - 13'(req.ay);
  assign prod  = mul_a * mul_b;
  assign trial = {rem_r, acc_r[17]};
  assign diff  = sub_a - sub_b;
  assign ge    = ~diff[26];
  assign root_step = ge ? ((root_r >> 1) + bit_r) : (root_r >> 1);

  // shared multiplier and subtractor operand select
  always_comb begin
    mul_a = mx_r;
    mul_b = mx_r;
    sub_a = {1'b0, acc_r};
    sub_b = {1'b0, root_r + bit_r};
    unique case (st_r)
      ecf_pkg::ST_SQY:  begin mul_a = my_r; mul_b = my_r; end
      ecf_pkg::ST_MULX: begin mul_a = mx_r; mul_b = {6'd0, dist_r}; end
      ecf_pkg::ST_MULY: begin mul_a = my_r; mul_b = {6'd0, dist_r}; end
      ecf_pkg::ST_DIVX, ecf_pkg::ST_DIVY: begin
        sub_a = {13'd0, trial};
        sub_b = {14'd0, len_r};
      end
      default: ;
    endcase
  end

  always_comb begin
    ox = negx_r ? -$signed({2'b00, qx_r}) : $signed({2'b00, qx_r});
    oy = negy_r ? -$signed({2'b00, q_r})  : $signed({2'b00, q_r});
    sx = lead_r ? (20'(bx_r) + ox) : (20'(bx_r) - ox);
    sy = lead_r ? (20'(by_r) + oy) : (20'(by_r) - oy);
  end

  assign done  = (st_r == ecf_pkg::ST_FIN);
  assign res_x = zero_r ? bx_r : ecf_pkg::sat_coord(sx);
  assign res_y = zero_r ? by_r : ecf_pkg::sat_coord(sy);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ecf_pkg::ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mx_r <= mx_nxt;     my_r <= my_nxt;
    negx_r <= negx_nxt; negy_r <= negy_nxt;
    bx_r <= bx_nxt;     by_r <= by_nxt;
    lead_r <= lead_nxt; dist_r <= dist_nxt;
    acc_r <= acc_nxt;   root_r <= root_nxt;
    bit_r <= bit_nxt;   len_r <= len_nxt;
    rem_r <= rem_nxt;   q_r <= q_nxt;
    qx_r <= qx_nxt;     cnt_r <= cnt_nxt;
    zero_r <= zero_nxt;
  end

  always_comb begin
    st_nxt = st_r;
    mx_nxt = mx_r;     my_nxt = my_r;
    negx_nxt = negx_r; negy_nxt = negy_r;
    bx_nxt = bx_r;     by_nxt = by_r;
    lead_nxt = lead_r; dist_nxt = dist_r;
    acc_nxt = acc_r;   root_nxt = root_r;
    bit_nxt = bit_r;   len_nxt = len_r;
    rem_nxt = rem_r;   q_nxt = q_r;
    qx_nxt = qx_r;     cnt_nxt = cnt_r;
    zero_nxt = zero_r;
    unique case (st_r)
      ecf_pkg::ST_IDLE: begin
        if (start) begin
          negx_nxt = dx[12];
          negy_nxt = dy[12];
          mx_nxt   = dx[12] ? 12'(-dx) : dx[11:0];
          my_nxt   = dy[12] ? 12'(-dy) : dy[11:0];
          bx_nxt   = req.bx;
          by_nxt   = req.by;
          lead_nxt = req.lead;
          dist_nxt = req.gap;
          st_nxt   = ecf_pkg::ST_SQX;
        end
      end
      ecf_pkg::ST_SQX: begin
        acc_nxt = {2'b00, prod};
        st_nxt  = ecf_pkg::ST_SQY;
      end
      ecf_pkg::ST_SQY: begin
        acc_nxt  = acc_r + {2'b00, prod};
        root_nxt = '0;
        bit_nxt  = 26'd1 << 24;
        cnt_nxt  = '0;
        st_nxt   = ecf_pkg::ST_ROOT;
      end
      ecf_pkg::ST_ROOT: begin
        // one digit of the floor square root per cycle
        if (ge) begin
          acc_nxt = diff[25:0];
        end
        root_nxt = root_step;
        bit_nxt  = bit_r >> 2;
        cnt_nxt  = cnt_r + 5'd1;
        if (cnt_r == 5'd12) begin
          len_nxt  = root_step[12:0];
          zero_nxt = (root_step == '0);
          st_nxt   = (root_step == '0) ? ecf_pkg::ST_FIN : ecf_pkg::ST_MULX;
        end
      end
      ecf_pkg::ST_MULX, ecf_pkg::ST_MULY: begin
        acc_nxt = {8'd0, prod[17:0]};
        rem_nxt = '0;
        q_nxt   = '0;
        cnt_nxt = '0;
        st_nxt  = (st_r == ecf_pkg::ST_MULX) ? ecf_pkg::ST_DIVX : ecf_pkg::ST_DIVY;
      end
      ecf_pkg::ST_DIVX, ecf_pkg::ST_DIVY: begin
        // restoring division, one quotient bit per cycle
        rem_nxt = ge ? diff[12:0] : trial[12:0];
        q_nxt   = {q_r[16:0], ge};
        acc_nxt = acc_r << 1;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd17) begin
          if (st_r == ecf_pkg::ST_DIVX) begin
            qx_nxt = {q_r[16:0], ge};
            st_nxt = ecf_pkg::ST_MULY;
          end else begin
            st_nxt = ecf_pkg::ST_FIN;
          end
        end
      end
      ecf_pkg::ST_FIN: begin
        st_nxt = ecf_pkg::ST_IDLE;
      end
      default: st_nxt = ecf_pkg::ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/echo_curve_follower.sv =====
`default_nettype none
// sequence: 30 echo steps per vertex (a zero-length segment skips the divisions), then
//   one emitted transaction per curve
// throughput: one vertex at a time, set by the single shared step unit
//   (square root and two divisions, one bit per cycle); a first vertex skips the steps
// reset: rst_n synchronous active low, clears control and sets the echo spacing to 8;
//   column storage is undefined until the first first_point vertex
module echo_curve_follower #(
  parameter int BEHIND_ECHOES = ecf_pkg::BehindEchoesDef,
  parameter int AHEAD_ECHOES  = ecf_pkg::AheadEchoesDef
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire ecf_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output ecf_pkg::out_t      out_data,
  input  wire logic          cfg_wr_en,
  input  wire logic [5:0]    cfg_wr_data
);
  localparam int Curves = BEHIND_ECHOES + AHEAD_ECHOES + 1;
  localparam int Aw     = $clog2(Curves);

  ecf_pkg::seq_state_t st_r, st_nxt;

  logic [5:0]         dist_r;
  logic [Aw-1:0]      s_r, s_nxt;        // curve under work or being emitted
  logic               lead_r, lead_nxt;  // leading half of the sweep
  logic               first_r, first_nxt;
  logic signed [11:0] px_r, px_nxt, py_r, py_nxt;    // input vertex
  logic signed [11:0] cx_r, cx_nxt, cy_r, cy_nxt;    // next-inner new vertex
  logic               ov_r, ov_nxt;
  ecf_pkg::out_t      od_r, od_nxt;

  // column stores: old vertices and vertices of the run in progress
  logic               col_we, new_we;
  logic [Aw-1:0]      col_raddr, new_waddr;
  logic [23:0]        col_rdata, new_rdata, new_wdata;
  ecf_pkg::step_req_t req;
  logic               step_start, step_done;
  logic signed [11:0] step_x, step_y;
  logic               in_acc;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (st_r != ecf_pkg::S_IDLE);
  assign out_valid = ov_r;
  assign out_data  = od_r;

  // trailing steps read their own column, leading steps the next-inner one
  assign col_raddr = lead_r ? (s_r - Aw'(1)) : s_r;
  // the offered transaction becomes the stored vertex of its curve
  assign col_we    = (st_r == ecf_pkg::S_EMIT_HOLD);

  assign req.ax   = col_rdata[23:12];
  assign req.ay   = col_rdata[11:0];
  assign req.bx   = cx_r;
  assign req.by   = cy_r;
  assign req.lead = lead_r;
  assign req.gap  = dist_r;
  assign step_start = (st_r == ecf_pkg::S_GO);

  always_comb begin
    new_we    = 1'b0;
    new_waddr = s_r;
    new_wdata = {step_x, step_y};
    if (st_r == ecf_pkg::S_IDLE) begin
      // base curve follows the input vertex directly
      new_we    = in_acc && !in_data.first_point;
      new_waddr = Aw'(BEHIND_ECHOES);
      new_wdata = {in_data.point_x, in_data.point_y};
    end else if (st_r == ecf_pkg::S_WAIT) begin
      new_we = step_done;
    end
  end

  ecf_ram #(.Width(24), .Depth(Curves)) u_col_ram (
    .clk   (clk),
    .we    (col_we),
    .waddr (s_r),
    .wdata ({od_r.echo_x, od_r.echo_y}),
    .raddr (col_raddr),
    .rdata (col_rdata)
  );

  ecf_ram #(.Width(24), .Depth(Curves)) u_new_ram (
    .clk   (clk),
    .we    (new_we),
    .waddr (new_waddr),
    .wdata (new_wdata),
    .raddr (s_r),
    .rdata (new_rdata)
  );

  ecf_step u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .start (step_start),
    .req   (req),
    .done  (step_done),
    .res_x (step_x),
    .res_y (step_y)
  );

  // echo spacing register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_r <= ecf_pkg::DistReset;
    end else if (cfg_wr_en) begin
      dist_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ecf_pkg::S_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r <= s_nxt;  lead_r <= lead_nxt;  first_r <= first_nxt;
    px_r <= px_nxt;  py_r <= py_nxt;
    cx_r <= cx_nxt;  cy_r <= cy_nxt;
    od_r <= od_nxt;
  end

  always_comb begin
    st_nxt = st_r;
    s_nxt = s_r;  lead_nxt = lead_r;  first_nxt = first_r;
    px_nxt = px_r;  py_nxt = py_r;
    cx_nxt = cx_r;  cy_nxt = cy_r;
    ov_nxt = ov_r;  od_nxt = od_r;
    unique case (st_r)
      ecf_pkg::S_IDLE: begin
        if (in_acc) begin
          px_nxt = in_data.point_x;
          py_nxt = in_data.point_y;
          cx_nxt = in_data.point_x;
          cy_nxt = in_data.point_y;
          first_nxt = in_data.first_point;
          lead_nxt  = 1'b0;
          if (in_data.first_point) begin
            s_nxt  = '0;
            st_nxt = ecf_pkg::S_EMIT_RD;
          end else begin
            s_nxt  = Aw'(BEHIND_ECHOES - 1);
            st_nxt = ecf_pkg::S_RD;
          end
        end
      end
      ecf_pkg::S_RD: st_nxt = ecf_pkg::S_GO;
      ecf_pkg::S_GO: st_nxt = ecf_pkg::S_WAIT;
      ecf_pkg::S_WAIT: begin
        if (step_done) begin
          cx_nxt = step_x;
          cy_nxt = step_y;
          st_nxt = ecf_pkg::S_RD;
          if (!lead_r) begin
            if (s_r == '0) begin
              // trailing side done, leading side starts from the vertex
              lead_nxt = 1'b1;
              s_nxt    = Aw'(BEHIND_ECHOES + 1);
              cx_nxt   = px_r;
              cy_nxt   = py_r;
            end else begin
              s_nxt = s_r - Aw'(1);
            end
          end else if (s_r == Aw'(Curves - 1)) begin
            s_nxt  = '0;
            st_nxt = ecf_pkg::S_EMIT_RD;
          end else begin
            s_nxt = s_r + Aw'(1);
          end
        end
      end
      ecf_pkg::S_EMIT_RD: st_nxt = ecf_pkg::S_EMIT_LD;
      ecf_pkg::S_EMIT_LD: begin
        ov_nxt = 1'b1;
        od_nxt.echo_index  = 5'(int'(s_r) - BEHIND_ECHOES);
        od_nxt.echo_x      = first_r ? px_r : new_rdata[23:12];
        od_nxt.echo_y      = first_r ? py_r : new_rdata[11:0];
        od_nxt.last_of_run = (s_r == Aw'(Curves - 1));
        st_nxt = ecf_pkg::S_EMIT_HOLD;
      end
      ecf_pkg::S_EMIT_HOLD: begin
        if (!out_stall) begin
          ov_nxt = 1'b0;
          if (od_r.last_of_run) begin
            st_nxt = ecf_pkg::S_IDLE;
          end else begin
            s_nxt  = s_r + Aw'(1);
            st_nxt = ecf_pkg::S_EMIT_RD;
          end
        end
      end
      default: st_nxt = ecf_pkg::S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/ecf_checker.sv =====
`default_nettype none
module ecf_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_stall,
  input wire logic          out_valid,
  input wire logic          out_stall,
  input wire ecf_pkg::out_t out_data
);
  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // block goes busy right after taking a vertex
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("not busy after input transaction");

  // the last result of a run ends the output burst
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_data.last_of_run |=> !out_valid)
    else $error("result after end of run");

  // no vertex is taken while results are pending
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken during output burst");
endmodule

bind echo_curve_follower ecf_checker u_ecf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
